// ===== hw/rtl/icy_md_pkg.sv =====
// Package for the stream metadata demultiplexer: result kinds, the result
// word layout and the title prefix table.
// No dependencies; used by every module of the block.
package icy_md_pkg;

   // Result kinds carried on the result channel's tuser.
   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_TITLE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Length of the title prefix StreamTitle=' in characters.
   localparam logic [3:0] PREFIX_LEN = 4'd13;

   // Byte that ends a title, and the byte that restarts a prefix match.
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_S     = 8'h53;

   // Output queue depth and pointer widths.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   // One result word.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // Up to two results caused by one input word.
   typedef struct packed {
      logic [1:0] count;
      result_type item0;
      result_type item1;
   } res_pair_type;

   // Character of the title prefix at a given position.
   function automatic logic [7:0] prefix_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h53; // S
         4'd1:    c = 8'h74; // t
         4'd2:    c = 8'h72; // r
         4'd3:    c = 8'h65; // e
         4'd4:    c = 8'h61; // a
         4'd5:    c = 8'h6D; // m
         4'd6:    c = 8'h54; // T
         4'd7:    c = 8'h69; // i
         4'd8:    c = 8'h74; // t
         4'd9:    c = 8'h6C; // l
         4'd10:   c = 8'h65; // e
         4'd11:   c = 8'h3D; // =
         4'd12:   c = 8'h27; // quote
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/icy_md_parser.sv =====
// Stream parser: audio counting, metadata block tracking, title matching
// and the one-byte title hold. Depends on icy_md_pkg.
module icy_md_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [15:0]               csr_wdata,
   input  logic                      in_take,
   input  logic [7:0]                in_byte,
   output icy_md_pkg::res_pair_type  res
);

   typedef enum logic [1:0] {
      PH_AUDIO = 2'd0,
      PH_META  = 2'd1
   } phase_type;

   typedef enum logic [1:0] {
      TP_SEARCH = 2'd0,
      TP_TITLE  = 2'd1,
      TP_DONE   = 2'd2
   } title_phase_type;

   logic [15:0]     interval_ff, interval_in;
   logic [15:0]     audio_count_ff, audio_count_in;
   phase_type       phase_ff, phase_in;
   logic [11:0]     meta_left_ff, meta_left_in;
   logic [3:0]      match_pos_ff, match_pos_in;
   title_phase_type title_phase_ff, title_phase_in;
   logic [7:0]      held_byte_ff, held_byte_in;
   logic            held_valid_ff, held_valid_in;

   // Next state and the results of the word being taken.
   always_comb begin
      logic       block_end;
      logic [1:0] n;
      logic [15:0] interval_cur;
      logic [15:0] count_cur;
      icy_md_pkg::result_type r0, r1;

      // A register write takes effect before a word taken in the same cycle.
      interval_cur   = csr_we ? csr_wdata : interval_ff;
      count_cur      = csr_we ? 16'd0 : audio_count_ff;

      interval_in    = interval_cur;
      audio_count_in = count_cur;
      phase_in       = phase_ff;
      meta_left_in   = meta_left_ff;
      match_pos_in   = match_pos_ff;
      title_phase_in = title_phase_ff;
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      block_end      = 1'b0;
      n              = 2'd0;
      r0             = '{kind: icy_md_pkg::KIND_AUDIO, data: in_byte, last: 1'b1};
      r1             = '{kind: icy_md_pkg::KIND_END, data: 8'h00, last: 1'b1};

      if (in_take) begin
         if (phase_ff == PH_AUDIO) begin
            if (interval_cur == 16'd0 || count_cur < interval_cur) begin
               // Audio byte passes through.
               if (interval_cur != 16'd0) begin
                  audio_count_in = count_cur + 16'd1;
               end
               n = 2'd1;
            end else begin
               // Length byte of a metadata block.
               audio_count_in = '0;
               meta_left_in   = {in_byte, 4'b0000};
               if (in_byte != 8'd0) begin
                  phase_in       = PH_META;
                  match_pos_in   = '0;
                  title_phase_in = TP_SEARCH;
                  held_byte_in   = '0;
                  held_valid_in  = 1'b0;
               end
            end
         end else begin
            // Metadata byte.
            meta_left_in = meta_left_ff - 12'd1;
            block_end    = (meta_left_in == 12'd0);
            if (block_end) begin
               phase_in = PH_AUDIO;
            end
            case (title_phase_ff)
               TP_SEARCH: begin
                  if (in_byte == 8'd0) begin
                     title_phase_in = TP_DONE;
                  end else if (match_pos_ff < icy_md_pkg::PREFIX_LEN &&
                               in_byte == icy_md_pkg::prefix_char(match_pos_ff)) begin
                     match_pos_in = match_pos_ff + 4'd1;
                     if (match_pos_in == icy_md_pkg::PREFIX_LEN) begin
                        title_phase_in = TP_TITLE;
                        held_valid_in  = 1'b0;
                     end
                  end else begin
                     match_pos_in = (in_byte == icy_md_pkg::CHAR_S) ? 4'd1 : 4'd0;
                  end
               end
               TP_TITLE: begin
                  r0.kind = icy_md_pkg::KIND_TITLE;
                  r0.data = held_byte_ff;
                  if (in_byte == icy_md_pkg::CHAR_SEMI || in_byte == 8'd0) begin
                     // The held byte is the closing quote and is dropped.
                     held_valid_in  = 1'b0;
                     title_phase_in = TP_DONE;
                     r0             = r1;
                     n              = 2'd1;
                  end else if (block_end) begin
                     held_valid_in  = 1'b0;
                     title_phase_in = TP_DONE;
                     if (held_valid_ff) begin
                        n = 2'd2;
                     end else begin
                        r0 = r1;
                        n  = 2'd1;
                     end
                  end else begin
                     held_byte_in  = in_byte;
                     held_valid_in = 1'b1;
                     n             = held_valid_ff ? 2'd1 : 2'd0;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      r0.last   = (n == 2'd1);
      res.count = n;
      res.item0 = r0;
      res.item1 = r1;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= '0;
         audio_count_ff <= '0;
         phase_ff       <= PH_AUDIO;
         meta_left_ff   <= '0;
         match_pos_ff   <= '0;
         title_phase_ff <= TP_SEARCH;
         held_byte_ff   <= '0;
         held_valid_ff  <= 1'b0;
      end else begin
         interval_ff    <= interval_in;
         audio_count_ff <= audio_count_in;
         phase_ff       <= phase_in;
         meta_left_ff   <= meta_left_in;
         match_pos_ff   <= match_pos_in;
         title_phase_ff <= title_phase_in;
         held_byte_ff   <= held_byte_in;
         held_valid_ff  <= held_valid_in;
      end
   end

endmodule

// ===== hw/rtl/icy_md_outq.sv =====
// Result queue: takes up to two result words per cycle and hands them out
// one per handshake. Depends on icy_md_pkg.
module icy_md_outq (
   input  logic                      clock,
   input  logic                      reset,
   input  icy_md_pkg::res_pair_type  push,
   output logic                      room,
   output logic                      out_valid,
   input  logic                      out_ready,
   output icy_md_pkg::result_type    out_word
);

   icy_md_pkg::result_type              entry_ff [icy_md_pkg::QUEUE_DEPTH];
   logic [icy_md_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [icy_md_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [icy_md_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                pop;
   logic [icy_md_pkg::PTR_W-1:0]        wr_next;

   // Room for the two words a single input can cause.
   assign room      = (cnt_ff <= icy_md_pkg::CNT_W'(icy_md_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (cnt_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   assign wr_next   = wr_ptr_ff + icy_md_pkg::PTR_W'(1);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + icy_md_pkg::PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + icy_md_pkg::PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + icy_md_pkg::CNT_W'(push.count) -
                  icy_md_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.item1;
      end
   end

endmodule

// ===== hw/rtl/icy_metadata_demux.sv =====
// Top level of the stream metadata demultiplexer: parser plus result queue.
// Depends on icy_md_pkg, icy_md_parser and icy_md_outq.
//
//   Channel   Direction  Ports            Content
//   req       in         req_t*           raw stream byte
//   rsp       out        rsp_t*           audio byte, title byte or end of title
//   csr       in         csr_we/wdata     meta_interval
//
// One input word is taken per cycle while the result queue has room for two
// words; results are registered in the result queue before they appear on rsp.
// A word that causes two results hands them out one per rsp handshake, so
// input falls below one word per cycle when rsp stalls or such words pile up.
// The four-entry result queue lets input continue while results wait.
// Reset is synchronous and clears all control state; the queue starts empty.
module icy_metadata_demux (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   icy_md_pkg::res_pair_type res;
   icy_md_pkg::result_type   out_word;
   logic                     room;

   icy_md_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_take   (req_tvalid & room),
      .in_byte   (req_tdata),
      .res       (res)
   );

   icy_md_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   // Port mapping of the result word.
   assign req_tready = room;
   assign rsp_tdata  = out_word.data;
   assign rsp_tuser  = out_word.kind;
   assign rsp_tlast  = out_word.last;

endmodule

// ===== hw/rtl/icy_md_checker.sv =====
// Port-level checks of the stream metadata demultiplexer, bound to the top.
// Depends on icy_md_pkg and icy_metadata_demux.
module icy_md_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // Only the three defined kinds appear.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined result kind");

   // An end of title carries a zero byte and closes the input's results.
   a_end_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == icy_md_pkg::KIND_END) |->
      (rsp_tdata == 8'h00 && rsp_tlast))
      else $error("malformed end of title");

   // An audio byte is always the only result of its input.
   a_audio_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == icy_md_pkg::KIND_AUDIO) |-> rsp_tlast)
      else $error("audio word without last");

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind icy_metadata_demux icy_md_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/icy_metadata_demux_chk.sv =====
// Checker for the stream metadata demultiplexer: watches the byte, result and
// register channels, predicts every result word and compares it field by field.
// Depends on icy_md_pkg for the result kind codes.
`timescale 1ns / 100ps

module icy_metadata_demux_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] out_byte
   input  logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);

   // Title prefix, first character in the top byte.
   localparam logic [103:0] TITLE_KEY = "StreamTitle='";
   localparam logic [3:0]   KEY_LEN   = 4'd13;
   localparam logic [7:0]   KEY_HEAD  = TITLE_KEY[103:96];
   localparam logic [7:0]   SEMICOLON = 8'h3B;

   typedef enum logic [1:0] {SEEK_TITLE, IN_TITLE, TITLE_DONE} title_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } demux_word_type;

   // Result words still owed by the block, oldest first.
   demux_word_type expected_words[$];

   // Predicted block state.
   logic [15:0]     interval;
   logic [15:0]     audio_cnt;
   logic            in_meta;
   logic [11:0]     meta_left;
   logic [3:0]      match_pos;
   title_state_type title_st;
   logic [7:0]      held_byte;
   logic            held_valid;

   always @(posedge clock) begin : model
      demux_word_type out_w [2];
      demux_word_type got;
      demux_word_type want;
      int             n_out;
      logic [7:0]     b;
      logic           block_end;

      if (reset) begin
         interval   = '0;
         audio_cnt  = '0;
         in_meta    = 1'b0;
         meta_left  = '0;
         match_pos  = '0;
         title_st   = SEEK_TITLE;
         held_byte  = '0;
         held_valid = 1'b0;
      end else begin
         // A register write also restarts the audio count.
         if (csr_we) begin
            interval  = csr_wdata;
            audio_cnt = '0;
         end

         // Predict the results of each accepted stream byte.
         if (req_tvalid && req_tready) begin
            b     = req_tdata;
            n_out = 0;
            if (!in_meta) begin
               if (interval == 16'd0 || audio_cnt < interval) begin
                  if (interval != 16'd0)
                     audio_cnt = audio_cnt + 16'd1;
                  out_w[0] = '{kind: icy_md_pkg::KIND_AUDIO, data: b, last: 1'b0};
                  n_out    = 1;
               end else begin
                  // Length byte: a zero length leaves us in the audio phase.
                  audio_cnt = '0;
                  meta_left = {b, 4'h0};
                  if (b != 8'h00) begin
                     in_meta    = 1'b1;
                     match_pos  = '0;
                     title_st   = SEEK_TITLE;
                     held_byte  = '0;
                     held_valid = 1'b0;
                  end
               end
            end else begin
               meta_left = meta_left - 12'd1;
               block_end = (meta_left == 12'd0);
               if (block_end)
                  in_meta = 1'b0;
               case (title_st)
                  SEEK_TITLE: begin
                     // A null stops the search; a mismatch restarts it, on S at once.
                     if (b == 8'h00) begin
                        title_st = TITLE_DONE;
                     end else if (match_pos < KEY_LEN &&
                                  b == TITLE_KEY[8 * (12 - int'(match_pos)) +: 8]) begin
                        match_pos = match_pos + 4'd1;
                        if (match_pos == KEY_LEN) begin
                           title_st   = IN_TITLE;
                           held_valid = 1'b0;
                        end
                     end else begin
                        match_pos = (b == KEY_HEAD) ? 4'd1 : 4'd0;
                     end
                  end
                  IN_TITLE: begin
                     // The held byte is the closing quote when a terminator shows up.
                     if (b == SEMICOLON || b == 8'h00) begin
                        held_valid   = 1'b0;
                        out_w[n_out] = '{kind: icy_md_pkg::KIND_END, data: 8'h00,
                                         last: 1'b0};
                        n_out++;
                        title_st     = TITLE_DONE;
                     end else begin
                        if (held_valid) begin
                           out_w[n_out] = '{kind: icy_md_pkg::KIND_TITLE, data: held_byte,
                                            last: 1'b0};
                           n_out++;
                        end
                        if (block_end) begin
                           // The final byte is taken as the quote and dropped.
                           held_valid   = 1'b0;
                           out_w[n_out] = '{kind: icy_md_pkg::KIND_END, data: 8'h00,
                                            last: 1'b0};
                           n_out++;
                           title_st     = TITLE_DONE;
                        end else begin
                           held_byte  = b;
                           held_valid = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            for (int i = 0; i < n_out; i++)
               expected_words.push_back('{out_w[i].kind, out_w[i].data, i == n_out - 1});
         end

         // Compare each accepted result word with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata, rsp_tlast};
            if (expected_words.size() == 0) begin
               $error("unexpected word: kind %0d, out_byte 0x%02h, last %0b",
                      got.kind, got.data, got.last);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                  fail_count++;
               end
               if (got.data !== want.data) begin
                  $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, got.data);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, got.last);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== dv/icy_metadata_demux_tb.sv =====
// Top of the metadata demultiplexer testbench: clock, reset, stream stimulus
// with framed metadata blocks, idle and stall phases, and the final verdict.
// Depends on icy_metadata_demux and icy_metadata_demux_chk.
`timescale 1ns / 100ps

module icy_metadata_demux_tb;

   localparam logic [103:0] TITLE_KEY     = "StreamTitle='";
   localparam int           PHASE_ITEMS   = 90;
   localparam int           BIG_LEN       = 40;
   localparam int           HOLD_CYCLES   = 300;
   localparam int           SETTLE_CYCLES = 8;
   localparam int           CYCLE_LIMIT   = 400000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int          fail_count;
   int          pending;
   int          send_gap;
   int          recv_stall;
   logic        hold_go;
   logic        hold_done;
   int unsigned cycles;

   // Framing tracker, so that length bytes land where the block expects them.
   int unsigned interval_now;
   int unsigned audio_seen;
   int unsigned meta_todo;
   logic [7:0]  block_q[$];

   icy_metadata_demux u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   icy_metadata_demux_chk u_chk (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off while the sender keeps going.
   initial begin
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done   = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // Random nonzero title character; never the terminator.
   function automatic logic [7:0] text_byte();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      if (c == ";")
         c = "'";
      return c;
   endfunction

   // Offers one word after a random gap; entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_interval(input logic [15:0] v);
      settle();
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we       <= 1'b0;
      interval_now  = v;
      audio_seen    = 0;
   endtask

   // One stretch of framed stream at a given interval.
   task automatic run_phase(input logic [15:0] iv, input int items, input bit hold,
                            input bit big_len);
      logic [7:0]  b;
      int unsigned len;
      int unsigned shape;
      int unsigned cut;
      int unsigned r;
      bit          pad_zero;

      set_interval(iv);
      if (hold)
         hold_go = 1'b1;
      repeat (items) begin
         if (meta_todo != 0) begin
            meta_todo--;
            b = block_q.pop_front();
         end else if (interval_now == 0 || audio_seen < interval_now) begin
            if (interval_now != 0)
               audio_seen++;
            b = 8'($urandom_range(255));
         end else begin
            // Length byte, mostly short blocks; empty ones now and then.
            audio_seen = 0;
            r          = $urandom_range(99);
            if (big_len)
               len = BIG_LEN;
            else if (r < 10)
               len = 0;
            else if (r < 80)
               len = $urandom_range(1, 2);
            else
               len = $urandom_range(3, 6);
            big_len   = 1'b0;
            b         = 8'(len);
            meta_todo = len * 16;

            // Block content: a title in various shapes, a broken prefix, or noise.
            block_q.delete();
            shape = $urandom_range(9);
            repeat ($urandom_range(2))
               block_q.push_back($urandom_range(1) ? TITLE_KEY[103:96] : text_byte());
            if (shape < 8) begin
               cut = (shape == 7) ? $urandom_range(12) : 13;
               for (int k = 0; k < cut; k++)
                  block_q.push_back(TITLE_KEY[8 * (12 - k) +: 8]);
               if (shape == 7) begin
                  block_q.push_back($urandom_range(1) ? 8'h00 : text_byte());
               end else begin
                  repeat ($urandom_range(12)) block_q.push_back(text_byte());
                  case ($urandom_range(4))
                     0: begin
                        block_q.push_back("'");
                        block_q.push_back(";");
                     end
                     1: block_q.push_back(";");
                     2: begin
                        block_q.push_back("'");
                        block_q.push_back(8'h00);
                     end
                     3: block_q.push_back(8'h00);
                     default: ;
                  endcase
               end
            end else begin
               repeat ($urandom_range(meta_todo)) block_q.push_back(8'($urandom_range(255)));
            end
            pad_zero = $urandom_range(1);
            while (block_q.size() < meta_todo)
               block_q.push_back(pad_zero ? 8'h00 : 8'($urandom_range(255)));
            while (block_q.size() > meta_todo)
               void'(block_q.pop_back());
         end
         send_byte(b);
      end
   endtask

   initial begin
      logic [15:0] iv;

      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      hold_go      = 1'b0;
      send_gap     = 0;
      recv_stall   = 0;
      interval_now = 0;
      audio_seen   = 0;
      meta_todo    = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: pass-through extremes, then one framed block with a short title
      // and an empty block.
      send_byte(8'h00);
      send_byte(8'hFF);
      set_interval(16'd2);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'h01);
      for (int k = 0; k < 13; k++)
         send_byte(TITLE_KEY[8 * (12 - k) +: 8]);
      send_byte("X");
      send_byte("'");
      send_byte(";");
      send_byte(8'h3C);
      send_byte(8'hC3);
      send_byte(8'h00);

      // Random phases; phases end mid-block, so some writes land inside a block.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       iv = 16'd0;
            1:       iv = 16'd1;
            2:       iv = 16'd0;
            3:       iv = 16'd5;
            4:       iv = 16'd65535;
            5:       iv = 16'd20;
            6:       iv = 16'd2;
            default: iv = 16'd3;
         endcase
         case (p % 4)
            0: begin
               send_gap   = 0;
               recv_stall = 0;
            end
            1: begin
               send_gap   = 55;
               recv_stall = 0;
            end
            2: begin
               send_gap   = 0;
               recv_stall = 55;
            end
            default: begin
               send_gap   = 6;
               recv_stall = 6;
            end
         endcase
         run_phase(iv, PHASE_ITEMS, p == 2, 1'b0);
      end

      // One long block, far beyond the random lengths.
      send_gap   = 6;
      recv_stall = 6;
      run_phase(16'd3, 4 + BIG_LEN * 16 + 40, 1'b0, 1'b1);

      settle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/icy_md_pkg.sv
hw/rtl/icy_md_parser.sv
hw/rtl/icy_md_outq.sv
hw/rtl/icy_metadata_demux.sv
hw/rtl/icy_md_checker.sv
dv/icy_metadata_demux_chk.sv
dv/icy_metadata_demux_tb.sv
